@@ src/gen_pkg.sv @@
package gen_pkg;

   localparam int KeyCodes   = 768;
   localparam int AxisCodes  = 64;
   localparam int MaxButtons = 256;
   localparam int HatCount   = 4;

   localparam int KeyAw  = $clog2(KeyCodes);
   localparam int AxisAw = $clog2(AxisCodes);
   localparam int HatAw  = (HatCount > 1) ? $clog2(HatCount) : 1;

   localparam int AxisEntryW = 1 + AxisAw + 32 + 32 + 31;

   localparam logic [9:0] HatFirst = 10'd16;
   localparam logic [9:0] HatLast  = 10'd23;
   localparam logic [15:0] QMax    = 16'sd32767;

   // item modes
   localparam logic [1:0] ModeEvent   = 2'd0;
   localparam logic [1:0] ModeBtnMap  = 2'd1;
   localparam logic [1:0] ModeAxisMap = 2'd2;

   // event kinds
   localparam logic [1:0] KindKey  = 2'd0;
   localparam logic [1:0] KindAbs  = 2'd1;

   // result kinds
   localparam logic [1:0] ResButton = 2'd0;
   localparam logic [1:0] ResHat    = 2'd1;
   localparam logic [1:0] ResAxis   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

endpackage

@@ src/gen_ram.sv @@
module gen_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/gamepad_event_normalizer_top.sv @@
// channel | direction | handshake            | fields
// req     | in        | req_valid/req_ready  | mode kind code value index range flat
// rsp     | out       | rsp_valid/rsp_ready  | kind index value
// One word at a time. A table write is taken in ST_IDLE alone; event words go through
// accept, read and decide, where unmapped or ignored events end, and key and hat words
// then give a result; an axis word runs the 49-step restoring divider before its result.
// After reset a clearing pass zeroes all 768 key map entries with req_ready low;
// the axis map valid bits are flip-flops cleared at once.
// A stalled result holds rsp_ and keeps req_ready low until taken.
module gamepad_event_normalizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_event_kind,
   input  logic [9:0]  req_code,
   input  logic signed [31:0] req_event_value,
   input  logic signed [8:0]  req_map_index,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   input  logic [30:0] req_dead_band,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_target_index,
   output logic signed [15:0] rsp_result_value
);
   import gen_pkg::*;

   state_type state_ff, state_in;

   // captured word
   logic [1:0]  kind_ff, kind_in;
   logic [9:0]  code_ff, code_in;
   logic signed [31:0] val_ff, val_in;

   // clearing pass address
   logic [KeyAw-1:0] clr_ff, clr_in;

   // valid bits and hat state
   logic [AxisCodes-1:0]  avld_ff, avld_in;
   logic [3:0] hat_ff [HatCount];
   logic [3:0] hat_in [HatCount];

   // memories
   logic              bm_we;
   logic [KeyAw-1:0]  bm_waddr;
   logic [8:0]        bm_wdata, bm_rd;
   logic              am_we;
   logic [AxisEntryW-1:0] am_wdata, am_rd;

   gen_ram #(.Width(9), .Depth(KeyCodes)) u_btn_map (
      .clock(clock), .wr_en(bm_we), .wr_addr(bm_waddr),
      .wr_data(bm_wdata), .rd_addr(code_ff[KeyAw-1:0]), .rd_data(bm_rd));

   gen_ram #(.Width(AxisEntryW), .Depth(AxisCodes)) u_axis_map (
      .clock(clock), .wr_en(am_we), .wr_addr(req_code[AxisAw-1:0]),
      .wr_data(am_wdata), .rd_addr(code_ff[AxisAw-1:0]), .rd_data(am_rd));

   assign am_wdata = {req_map_index[AxisAw-1:0], req_range_low, req_range_high,
                      req_dead_band, 1'b0};

   // axis entry fields
   logic [AxisAw-1:0] ax_idx;
   logic signed [33:0] lo, hi, mid, dv, span;
   logic [30:0] flat;
   assign ax_idx = am_rd[AxisEntryW-1 -: AxisAw];
   assign lo   = 34'(signed'(am_rd[AxisEntryW-AxisAw-1 -: 32]));
   assign hi   = 34'(signed'(am_rd[AxisEntryW-AxisAw-33 -: 32]));
   assign flat = am_rd[31:1];
   logic signed [33:0] sum;
   assign sum  = lo + hi;
   // truncate toward zero
   assign mid  = (sum + $signed({33'd0, sum[33]})) >>> 1;
   assign dv   = 34'(val_ff) - mid;
   assign span = dv[33] ? (lo - mid) : (hi - mid);

   // divider state
   logic [48:0] num_ff, num_in;     // |d| << 15
   logic [33:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [48:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;   // zero span
   logic        dsgn_ff, dsgn_in;
   logic        dz_ff, dz_in;
   logic        flatz_ff, flatz_in;
   logic [7:0]  ridx_ff, ridx_in;

   // result register
   logic [1:0]  rk_ff, rk_in;
   logic [7:0]  ri_ff, ri_in;
   logic [15:0] rv_ff, rv_in;

   logic [33:0] ad;
   assign ad = dv[33] ? 34'(-dv) : dv;

   logic [34:0] trial;
   assign trial = {rem_ff, num_ff[48]} - {1'b0, den_ff};

   logic [7:0] bidx;
   logic [3:0] hm;
   logic       vert;
   assign bidx = bm_rd[7:0];
   assign vert = code_ff[0];

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff; code_in = code_ff; val_in = val_ff;
      clr_in = clr_ff;
      avld_in = avld_ff;
      for (int i = 0; i < HatCount; i++) hat_in[i] = hat_ff[i];
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; zero_in = zero_ff; dsgn_in = dsgn_ff;
      dz_in = dz_ff; flatz_in = flatz_ff; ridx_in = ridx_ff;
      rk_in = rk_ff; ri_in = ri_ff; rv_in = rv_ff;
      bm_we = 1'b0; am_we = 1'b0; hm = 4'd0;
      bm_waddr = req_code[KeyAw-1:0];
      bm_wdata = {!req_map_index[8], req_map_index[7:0]};
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            // zero one key map entry per cycle
            bm_we = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == KeyAw'(KeyCodes - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_event_kind;
               code_in = req_code; val_in = req_event_value;
               if (req_mode == ModeBtnMap) begin
                  if (req_code < 10'(KeyCodes)) begin
                     bm_we = 1'b1;
                  end
               end else if (req_mode == ModeAxisMap) begin
                  if (req_code < 10'(AxisCodes)) begin
                     am_we = 1'b1;
                     avld_in[req_code[AxisAw-1:0]] = !req_map_index[8];
                  end
               end else if (req_mode == ModeEvent) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (kind_ff == KindKey) begin
               if (code_ff < 10'(KeyCodes) && bm_rd[8] &&
                   32'(bidx) < 32'(MaxButtons)) begin
                  rk_in = ResButton; ri_in = bidx;
                  rv_in = {15'd0, val_ff != 0};
                  state_in = ST_OUT;
               end
            end else if (kind_ff == KindAbs) begin
               if (code_ff < 10'(AxisCodes) && avld_ff[code_ff[AxisAw-1:0]]) begin
                  if (code_ff >= HatFirst && code_ff <= HatLast) begin
                     if (32'(ax_idx) < 32'(HatCount)) begin
                        hm = hat_ff[ax_idx[HatAw-1:0]] & (vert ? 4'b1010 : 4'b0101);
                        if (val_ff != 0) begin
                           if (vert) hm = hm | (val_ff > 0 ? 4'd4 : 4'd1);
                           else      hm = hm | (val_ff > 0 ? 4'd2 : 4'd8);
                        end
                        hat_in[ax_idx[HatAw-1:0]] = hm;
                        rk_in = ResHat; ri_in = 8'(ax_idx); rv_in = {12'd0, hm};
                        state_in = ST_OUT;
                     end
                  end else begin
                     num_in = {ad, 15'd0};
                     den_in = span[33] ? 34'(-span) : span;
                     neg_in = span[33];
                     zero_in = (span == 0);
                     dsgn_in = dv[33];
                     dz_in = (dv == 0);
                     flatz_in = ad < {3'd0, flat};
                     ridx_in = 8'(ax_idx);
                     rem_in = '0; quo_in = '0; cnt_in = '0;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            num_in = {num_ff[47:0], 1'b0};
            if (!trial[34]) begin
               rem_in = trial[33:0];
               quo_in = {quo_ff[47:0], 1'b1};
            end else begin
               rem_in = {rem_ff[32:0], num_ff[48]};
               quo_in = {quo_ff[47:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rk_in = ResAxis; ri_in = ridx_ff;
            if (flatz_ff) rv_in = '0;
            else if (zero_ff) rv_in = dz_ff ? 16'd0 : (dsgn_ff ? -QMax : QMax);
            else if (quo_ff > 49'(QMax)) rv_in = neg_ff ? -QMax : QMax;
            else rv_in = neg_ff ? -quo_ff[15:0] : quo_ff[15:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result_kind = rk_ff;
   assign rsp_target_index = ri_ff;
   assign rsp_result_value = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         avld_ff <= '0;
         for (int i = 0; i < HatCount; i++) hat_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         avld_ff <= avld_in;
         for (int i = 0; i < HatCount; i++) hat_ff[i] <= hat_in[i];
      end
      kind_ff <= kind_in; code_ff <= code_in; val_ff <= val_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; zero_ff <= zero_in; dsgn_ff <= dsgn_in;
      dz_ff <= dz_in; flatz_ff <= flatz_in; ridx_ff <= ridx_in;
      rk_ff <= rk_in; ri_ff <= ri_in; rv_ff <= rv_in;
   end

endmodule

@@ src/gen_checker.sv @@
module gen_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_result_value
);

   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("result changed while stalled");

   // no new word while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   // no result in the cycle after a word is taken
   a_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");

   // result kinds in range
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind != 2'd3)
      else $error("bad result kind");

   // axis value never full negative scale
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_value != 16'h8000)
      else $error("value out of range");

endmodule

bind gamepad_event_normalizer_top gen_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_kind(rsp_result_kind), .rsp_result_value(rsp_result_value));

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import gen_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [1:0]  req_event_kind = '0;
   logic [9:0]  req_code = '0;
   logic signed [31:0] req_event_value = '0;
   logic signed [8:0]  req_map_index = '0;
   logic signed [31:0] req_range_low = '0;
   logic signed [31:0] req_range_high = '0;
   logic [30:0] req_dead_band = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_target_index;
   logic signed [15:0] rsp_result_value;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  kind;
      logic [9:0]  code;
      logic [31:0] value;
      logic [8:0]  idx;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [30:0] flat;
   } word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  index;
      logic [15:0] value;
   } event_out_type;

   word_type      pending_words[$];
   event_out_type expected_events[$];
   int         errors = 0;
   int         cycles = 0;
   bit         stim_done = 1'b0;

   // shadow of the block's tables
   logic [8:0]  key_table[KeyCodes];
   logic [6:0]  axis_table[AxisCodes];
   logic signed [31:0] axis_lo_tab[AxisCodes];
   logic signed [31:0] axis_hi_tab[AxisCodes];
   logic [30:0] axis_flat_tab[AxisCodes];
   logic        btn_state[MaxButtons];
   logic [3:0]  hat_state[HatCount];

   gamepad_event_normalizer_top u_top (.*);

   always #1 clock = ~clock;

   function automatic logic signed [15:0] scale_axis(int c, logic signed [31:0] v);
      longint lo, hi, mid, d, span, ad, q;
      logic signed [15:0] r;
      lo = axis_lo_tab[c];
      hi = axis_hi_tab[c];
      mid = (lo + hi) / 2;
      d = v - mid;
      span = (d >= 0) ? hi - mid : lo - mid;
      ad = (d < 0) ? -d : d;
      if (span == 0) begin
         r = (d == 0) ? 16'sd0 : ((d > 0) ? 16'sd32767 : -16'sd32767);
      end else begin
         q = (ad <<< 15) / ((span < 0) ? -span : span);
         if (q > 32767) q = 32767;
         r = 16'((span < 0) ? -q : q);
      end
      if (ad < longint'(axis_flat_tab[c])) r = '0;
      return r;
   endfunction

   // update shadow state and queue the expected event, if any
   task automatic predict_event(word_type w);
      event_out_type e;
      logic [7:0] b;
      logic [5:0] a;
      logic [3:0] m;
      bit         vert;
      if (w.mode == ModeBtnMap) begin
         if (w.code < KeyCodes)
            key_table[w.code] = w.idx[8] ? 9'd0 : {1'b1, w.idx[7:0]};
      end else if (w.mode == ModeAxisMap) begin
         if (w.code < AxisCodes) begin
            axis_table[w.code] = w.idx[8] ? 7'd0 : {1'b1, w.idx[5:0]};
            axis_lo_tab[w.code] = w.lo;
            axis_hi_tab[w.code] = w.hi;
            axis_flat_tab[w.code] = w.flat;
         end
      end else if (w.mode == ModeEvent) begin
         if (w.kind == KindKey) begin
            if (w.code < KeyCodes && key_table[w.code][8]) begin
               b = key_table[w.code][7:0];
               btn_state[b] = (w.value != 0);
               e = '{ResButton, b, {15'd0, btn_state[b]}};
               expected_events.push_back(e);
            end
         end else if (w.kind == KindAbs) begin
            if (w.code < AxisCodes && axis_table[w.code][6]) begin
               a = axis_table[w.code][5:0];
               if (w.code >= HatFirst && w.code <= HatLast) begin
                  if (a < HatCount) begin
                     vert = w.code[0];
                     m = hat_state[a] & (vert ? 4'b1010 : 4'b0101);
                     if (w.value != 0) begin
                        if (vert) m |= ($signed(w.value) > 0) ? 4'd4 : 4'd1;
                        else m |= ($signed(w.value) > 0) ? 4'd2 : 4'd8;
                     end
                     hat_state[a] = m;
                     e = '{ResHat, {2'd0, a}, {12'd0, m}};
                     expected_events.push_back(e);
                  end
               end else begin
                  e = '{ResAxis, {2'd0, a}, scale_axis(w.code, w.value)};
                  expected_events.push_back(e);
               end
            end
         end
      end
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return $urandom;
         default: return 32'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   // random word, biased toward mapped codes and well-formed events
   function automatic word_type rand_word();
      word_type w;
      int    r;
      w = '0;
      w.value = rand_value();
      w.lo = $urandom;
      w.hi = $urandom;
      w.flat = 31'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         w.mode = ModeBtnMap;
         w.code = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31));
         w.idx = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 255));
      end else if (r < 16) begin
         w.mode = ModeAxisMap;
         w.code = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31));
         w.idx = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 5));
         if ($urandom_range(0, 2) != 0) begin
            w.lo = 32'($signed($urandom_range(0, 2000)) - 1000);
            w.hi = w.lo + $urandom_range(0, 3000) - 300;
            w.flat = 31'($urandom_range(0, 200));
         end
      end else if (r < 19) begin
         w.mode = 2'd3;
         w.code = 10'($urandom);
      end else begin
         w.mode = ModeEvent;
         w.kind = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                              : 2'($urandom_range(0, 1));
         w.code = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31));
         w.idx = 9'($urandom);
      end
      return w;
   endfunction

   // pending word fill
   initial begin
      for (int i = 0; i < KeyCodes; i++) key_table[i] = '0;
      for (int i = 0; i < AxisCodes; i++) axis_table[i] = '0;
      for (int i = 0; i < MaxButtons; i++) btn_state[i] = 1'b0;
      for (int i = 0; i < HatCount; i++) hat_state[i] = '0;
      // directed: maps, extremes, hats, zero span, inverted range, ignored
      pending_words.push_back('{ModeBtnMap, 2'd0, 10'd767, 32'd0, 9'd255, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeBtnMap, 2'd0, 10'd0, 32'd0, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeBtnMap, 2'd0, 10'd800, 32'd0, 9'd3, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindKey, 10'd767, 32'h8000_0000, 9'h1ff, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindKey, 10'd767, 32'h8000_0000, 9'h1ff, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindKey, 10'd0, 32'd0, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindKey, 10'd5, 32'd1, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd16, 32'd0, 9'd3, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd17, 32'd0, 9'd3, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd18, 32'd0, 9'd4, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd16, 32'h7fff_ffff, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd17, 32'hffff_ffff, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd16, 32'd0, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd18, 32'd1, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd63, 32'd0, 9'd127, 32'h8000_0000,
                                32'h7fff_ffff, 31'h7fff_ffff});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd63, 32'h7fff_ffff, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd0, 32'd0, 9'd1, 32'h8000_0000,
                                32'h7fff_ffff, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd0, 32'h8000_0000, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd0, 32'h7fff_ffff, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd1, 32'd0, 9'd2, 32'd100, 32'd100, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd1, 32'd50, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd1, 32'd100, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{ModeAxisMap, 2'd0, 10'd2, 32'd0, 9'd3, 32'd500, 32'hffff_fe0c, 31'd10});
      pending_words.push_back('{ModeEvent, KindAbs, 10'd2, 32'd300, 9'd0, 32'd0, 32'd0, 31'd0});
      pending_words.push_back('{2'd3, KindKey, 10'd0, 32'd1, 9'd0, 32'd0, 32'd0, 31'd0});
      for (int i = 0; i < 1300; i++) pending_words.push_back(rand_word());
      stim_done = 1'b1;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold the offered word
      end else begin
         if (req_valid && req_ready) predict_event(pending_words.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if ((req_valid && req_ready ? pending_words.size() > 0
                                              : pending_words.size() > 0)) begin
            w = pending_words[0];
            req_valid <= 1'b1;
            req_mode <= w.mode;
            req_event_kind <= w.kind;
            req_code <= w.code;
            req_event_value <= w.value;
            req_map_index <= w.idx;
            req_range_low <= w.lo;
            req_range_high <= w.hi;
            req_dead_band <= w.flat;
            send_gap <= $urandom_range(0, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor, with one long hold-off early in the run
   int recv_gap = 0;
   int hold_off = 400;
   always @(posedge clock) begin
      event_out_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_kind, rsp_target_index, rsp_result_value};
            if (expected_events.size() == 0) begin
               $error("unexpected word kind=%0d index=%0d value=%0d",
                      got.kind, got.index, $signed(got.value));
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (got.kind !== want.kind) begin
                  $error("result_kind exp %0d got %0d", want.kind, got.kind);
                  errors++;
               end
               if (got.index !== want.index) begin
                  $error("target_index exp %0d got %0d", want.index, got.index);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $error("result_value exp %0d got %0d", $signed(want.value),
                         $signed(got.value));
                  errors++;
               end
            end
            recv_gap = $urandom_range(0, 7);
         end
         if (cycles > 300 && hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_words.size() == 0 && !req_valid);
      @(posedge clock);
      wait (expected_events.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ gamepad_event_normalizer_top.f @@
src/gen_pkg.sv
src/gen_ram.sv
src/gamepad_event_normalizer_top.sv
src/gen_checker.sv
tb/tb.sv
